FILE: rtl/core/uas_pkg.sv
// ----------------------------------------------------------------------------
// uas_pkg
// Shared constants, types and helpers for the URI authority splitter.
// ----------------------------------------------------------------------------
package uas_pkg;

    // Size limits of the accepted text and of each reported field.
    localparam int AUTH_MAX = 256;
    localparam int USER_MAX = 64;
    localparam int PASS_MAX = 64;
    localparam int HOST_MAX = 128;
    localparam int PORT_MAX = 8;

    // Byte counter holds 0..AUTH_MAX; a position holds 0..AUTH_MAX-1.
    localparam int CNT_W = $clog2(AUTH_MAX + 1);
    localparam int POS_W = $clog2(AUTH_MAX);

    // Separator and digit characters.
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Scan state carried from one word to the next.
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [POS_W-1:0] at_pos;
        logic             at_seen;
        logic [POS_W-1:0] colon_first_pos;
        logic             colon_first_seen;
        logic [POS_W-1:0] colon_after_at_pos;
        logic             colon_after_at_seen;
        logic             port_bad_first;
        logic             port_bad_after;
        logic             overflow_seen;
    } t_scan_state;

    // One result word.
    typedef struct packed {
        logic [6:0] user_len;
        logic [7:0] pass_start;
        logic [6:0] pass_len;
        logic [7:0] host_start;
        logic [7:0] host_len;
        logic [7:0] port_start;
        logic [3:0] port_len;
        logic       too_long;
    } t_result;

    // Smaller of a value and a limit.
    function automatic logic [CNT_W-1:0] clip(input logic [CNT_W-1:0] v,
                                              input logic [CNT_W-1:0] lim);
        clip = (v < lim) ? v : lim;
    endfunction

endpackage

FILE: rtl/core/uas_if.sv
// ----------------------------------------------------------------------------
// uas_in_if / uas_out_if
// Valid/ready channels for the authority bytes and the split result.
// ----------------------------------------------------------------------------
interface uas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface uas_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] user_len;
    logic [7:0] pass_start;
    logic [6:0] pass_len;
    logic [7:0] host_start;
    logic [7:0] host_len;
    logic [7:0] port_start;
    logic [3:0] port_len;
    logic       too_long;

    modport source (output valid, output user_len, output pass_start, output pass_len,
                    output host_start, output host_len, output port_start,
                    output port_len, output too_long, input ready);
    modport sink   (input valid, input user_len, input pass_start, input pass_len,
                    input host_start, input host_len, input port_start,
                    input port_len, input too_long, output ready);
endinterface

FILE: rtl/core/uas_scan.sv
// ----------------------------------------------------------------------------
// uas_scan
// Per-byte scan: tracks separators, port digit checks and the byte count.
// ----------------------------------------------------------------------------
module uas_scan import uas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_scan_state o_next
);

    t_scan_state r_state;
    t_scan_state n_state;

    function automatic logic port_bad(input logic seen, input logic [POS_W-1:0] cpos,
                                      input logic [CNT_W-1:0] p, input logic digit);
        logic [CNT_W-1:0] gap;
        gap = p - CNT_W'(cpos);
        port_bad = seen && (p > CNT_W'(cpos)) &&
                   ((gap - CNT_W'(1)) < CNT_W'(PORT_MAX)) && !digit;
    endfunction

    always_comb begin
        logic [CNT_W-1:0] p;
        logic [POS_W-1:0] pos;
        logic             digit;
        p       = r_state.byte_count;
        pos     = p[POS_W-1:0];
        digit   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
        n_state = r_state;
        if (p < CNT_W'(AUTH_MAX)) begin
            if (port_bad(r_state.colon_first_seen, r_state.colon_first_pos, p, digit)) begin
                n_state.port_bad_first = 1'b1;
            end
            if (port_bad(r_state.colon_after_at_seen, r_state.colon_after_at_pos, p,
                         digit)) begin
                n_state.port_bad_after = 1'b1;
            end
            if (i_byte == CHAR_AT && !r_state.at_seen) begin
                n_state.at_seen = 1'b1;
                n_state.at_pos  = pos;
            end
            if (i_byte == CHAR_COLON) begin
                if (!r_state.colon_first_seen) begin
                    n_state.colon_first_seen = 1'b1;
                    n_state.colon_first_pos  = pos;
                end
                if (r_state.at_seen && !r_state.colon_after_at_seen) begin
                    n_state.colon_after_at_seen = 1'b1;
                    n_state.colon_after_at_pos  = pos;
                end
            end
            n_state.byte_count = p + CNT_W'(1);
        end else begin
            n_state.overflow_seen = 1'b1;
        end
    end

    // The state starts over once the final byte has been scanned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= i_last ? '0 : n_state;
        end
    end

    assign o_next = n_state;

endmodule

FILE: rtl/core/uas_split.sv
// ----------------------------------------------------------------------------
// uas_split
// Turns the final scan state into offsets and clipped lengths.
// ----------------------------------------------------------------------------
module uas_split import uas_pkg::*; (
    input  t_scan_state i_state,
    output t_result     o_result
);

    always_comb begin
        logic             cred;
        logic             cseen;
        logic             cbad;
        logic [CNT_W-1:0] cpos;
        logic [CNT_W-1:0] at_p;
        logic [CNT_W-1:0] cf_p;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] rest;
        logic [CNT_W-1:0] hl;
        logic [CNT_W-1:0] pl;
        logic [CNT_W-1:0] user_len;
        logic [CNT_W-1:0] pass_start;
        logic [CNT_W-1:0] pass_len;
        logic [CNT_W-1:0] host_len;
        logic [CNT_W-1:0] port_start;
        logic [CNT_W-1:0] port_len;

        len        = i_state.byte_count;
        at_p       = CNT_W'(i_state.at_pos);
        cf_p       = CNT_W'(i_state.colon_first_pos);
        cred       = i_state.at_seen && (at_p != '0);
        user_len   = '0;
        pass_start = '0;
        pass_len   = '0;
        port_start = '0;
        port_len   = '0;
        idx        = '0;
        hl         = '0;
        pl         = '0;

        if (cred) begin
            if (i_state.colon_first_seen && (cf_p != '0) && (cf_p < at_p)) begin
                user_len   = clip(cf_p, CNT_W'(USER_MAX));
                pass_start = cf_p + CNT_W'(1);
                pass_len   = clip(at_p - cf_p - CNT_W'(1), CNT_W'(PASS_MAX));
            end else begin
                user_len = clip(at_p, CNT_W'(USER_MAX));
            end
            idx   = at_p + CNT_W'(1);
            cseen = i_state.colon_after_at_seen;
            cpos  = CNT_W'(i_state.colon_after_at_pos);
            cbad  = i_state.port_bad_after;
        end else begin
            cseen = i_state.colon_first_seen;
            cpos  = cf_p;
            cbad  = i_state.port_bad_first;
        end

        rest = (len >= idx) ? (len - idx) : '0;

        // A colon right at the start of the location does not split off a port.
        if (cseen && (cpos > idx)) begin
            hl         = cpos - idx;
            pl         = rest - hl - CNT_W'(1);
            host_len   = clip(hl, CNT_W'(HOST_MAX));
            port_start = cpos + CNT_W'(1);
            port_len   = cbad ? '0 : clip(pl, CNT_W'(PORT_MAX));
        end else begin
            host_len = clip(rest, CNT_W'(HOST_MAX));
        end

        o_result.user_len   = user_len[6:0];
        o_result.pass_start = pass_start[7:0];
        o_result.pass_len   = pass_len[6:0];
        o_result.host_start = idx[7:0];
        o_result.host_len   = host_len[7:0];
        o_result.port_start = port_start[7:0];
        o_result.port_len   = port_len[3:0];
        o_result.too_long   = i_state.overflow_seen;
    end

endmodule

FILE: rtl/core/uri_authority_splitter.sv
// ----------------------------------------------------------------------------
// uri_authority_splitter
// Splits a byte stream of a URI authority into user, password, host and port.
// ----------------------------------------------------------------------------
// Path: a byte waits in the input register; for a final byte the scan and split
// logic result is then captured in the output register.
// Throughput: one byte per cycle, unless a final byte waits for the output slot.
// Reset: synchronous active-low i_rst_n clears valids and the scan state.
// ----------------------------------------------------------------------------
module uri_authority_splitter import uas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uas_in_if.sink    i_in,
    uas_out_if.source o_out
);

    // Input register: holds one accepted byte until the scan stage takes it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register: holds one finished result word.
    logic    r_out_valid;
    t_result r_out;

    t_scan_state scan_next;
    t_result     split_res;
    logic        advance;

    // A byte that does not end the authority never needs the output slot, so
    // it moves on even while a result waits downstream. Only a final byte
    // waits for the output register to be free or being drained.
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);

    // The input register refills in the same cycle it empties.
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.byte_in;
            r_in_last <= i_in.last_byte;
        end
    end

    // Scan stage: the separator tracker updates with the current byte, and
    // the split logic works on that updated state so the final byte counts.
    uas_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (scan_next)
    );

    uas_split u_split (
        .i_state  (scan_next),
        .o_result (split_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= split_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.user_len   = r_out.user_len;
    assign o_out.pass_start = r_out.pass_start;
    assign o_out.pass_len   = r_out.pass_len;
    assign o_out.host_start = r_out.host_start;
    assign o_out.host_len   = r_out.host_len;
    assign o_out.port_start = r_out.port_start;
    assign o_out.port_len   = r_out.port_len;
    assign o_out.too_long   = r_out.too_long;

    // A final byte must stay in the input register while the result slot is
    // occupied and not drained.
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !o_out.ready) |=> r_in_valid)
        else $error("final byte left the input register while the result was stalled");

    // A completed result is always presented in the cycle after it is formed.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> r_out_valid)
        else $error("result was formed but not presented");

    // Overflow can only be flagged once the byte counter has saturated.
    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && scan_next.overflow_seen) |->
            (scan_next.byte_count == CNT_W'(AUTH_MAX)))
        else $error("overflow flagged before the byte limit was reached");

    // Reported host and port lengths never exceed their clip limits.
    a_len_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.host_len <= 8'(HOST_MAX)) &&
                         (r_out.port_len <= 4'(PORT_MAX))))
        else $error("reported length exceeds its limit");

endmodule

FILE: tb/tb_uri_authority_splitter.sv
// ----------------------------------------------------------------------------
// tb_uri_authority_splitter
// Self-checking bench for the URI authority splitter. Authorities are sent
// one byte per word: first a set of hand-picked cases, then random ones that
// are mostly well formed, with broken and noisy text mixed in. A scoreboard
// predicts the split of each authority and checks every result word
// field by field.
// ----------------------------------------------------------------------------
module tb_uri_authority_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import uas_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    // The longest legal gap is a run of receiver or sender idles at 65 %,
    // which never comes close to this.
    localparam int STALL_LIMIT  = 2000;
    // Extra cycles after the last result.
    localparam int DRAIN_CYCLES = 20;
    // Random bytes and authorities per idling phase.
    localparam int PHASE_BYTES  = 40;
    localparam int PHASE_AUTHS  = 4;

    typedef enum int {
        CLS_NAME,   // letters, digits and the usual host punctuation
        CLS_PLAIN,  // any byte except the two separators
        CLS_DIGIT
    } t_char_class;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the scan state, predicts one result
    // per authority and checks result words against the oldest prediction.
    // ------------------------------------------------------------------------
    class authority_scoreboard;
        int unsigned count;
        int unsigned at_pos;
        bit          at_seen;
        int unsigned colon_pos;     // first ':' anywhere
        bit          colon_seen;
        int unsigned tail_pos;      // first ':' after the first '@'
        bit          tail_seen;
        bit          bad_first;
        bit          bad_after;
        bit          overflow;

        t_result expected_splits[$];
        int      errors;
        int      words_checked;
        int      overlong_words;
        int      port_words;

        function new();
            clear_scan();
            errors = 0;
            words_checked = 0;
            overlong_words = 0;
            port_words = 0;
        endfunction

        function void clear_scan();
            count = 0;
            at_pos = 0;
            at_seen = 0;
            colon_pos = 0;
            colon_seen = 0;
            tail_pos = 0;
            tail_seen = 0;
            bad_first = 0;
            bad_after = 0;
            overflow = 0;
        endfunction

        function int unsigned at_most(int unsigned v, int unsigned lim);
            return (v < lim) ? v : lim;
        endfunction

        // Called for every accepted input word.
        function void note_byte(logic [7:0] b, logic is_last);
            int unsigned p, len, idx, rest, cpos, hl;
            bit digit, cred, cseen, cbad;
            t_result r;
            if (count < AUTH_MAX) begin
                p = count;
                digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
                // A non-digit among the first PORT_MAX bytes after a colon
                // spoils the port that colon would start.
                if (colon_seen && p > colon_pos && (p - colon_pos - 1) < PORT_MAX && !digit)
                    bad_first = 1;
                if (tail_seen && p > tail_pos && (p - tail_pos - 1) < PORT_MAX && !digit)
                    bad_after = 1;
                if (b == CHAR_AT && !at_seen) begin
                    at_seen = 1;
                    at_pos = p;
                end
                if (b == CHAR_COLON) begin
                    if (!colon_seen) begin
                        colon_seen = 1;
                        colon_pos = p;
                    end
                    if (at_seen && !tail_seen) begin
                        tail_seen = 1;
                        tail_pos = p;
                    end
                end
                count = p + 1;
            end else begin
                overflow = 1;
            end
            if (!is_last)
                return;

            r = '0;
            len = count;
            idx = 0;
            cred = at_seen && at_pos > 0;
            if (cred) begin
                if (colon_seen && colon_pos > 0 && colon_pos < at_pos) begin
                    r.user_len   = 7'(at_most(colon_pos, USER_MAX));
                    r.pass_start = 8'(colon_pos + 1);
                    r.pass_len   = 7'(at_most(at_pos - colon_pos - 1, PASS_MAX));
                end else begin
                    r.user_len = 7'(at_most(at_pos, USER_MAX));
                end
                idx = at_pos + 1;
                cseen = tail_seen;
                cpos = tail_pos;
                cbad = bad_after;
            end else begin
                cseen = colon_seen;
                cpos = colon_pos;
                cbad = bad_first;
            end
            rest = (len >= idx) ? len - idx : 0;
            // Offsets past the last position wrap in their 8-bit fields.
            r.host_start = 8'(idx);
            if (cseen && cpos > idx) begin
                hl = cpos - idx;
                r.host_len   = 8'(at_most(hl, HOST_MAX));
                r.port_start = 8'(cpos + 1);
                r.port_len   = 4'(cbad ? 0 : at_most(rest - hl - 1, PORT_MAX));
            end else begin
                r.host_len = 8'(at_most(rest, HOST_MAX));
            end
            r.too_long = overflow;
            expected_splits.push_back(r);
            clear_scan();
        endfunction

        function void compare_field(string name, logic [8:0] want, logic [8:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result word.
        function void check_word(t_result got);
            t_result want;
            if (expected_splits.size() == 0) begin
                $error("result word arrived with no authority outstanding");
                errors++;
                return;
            end
            want = expected_splits.pop_front();
            compare_field("user_len",   9'(want.user_len),   9'(got.user_len));
            compare_field("pass_start", 9'(want.pass_start), 9'(got.pass_start));
            compare_field("pass_len",   9'(want.pass_len),   9'(got.pass_len));
            compare_field("host_start", 9'(want.host_start), 9'(got.host_start));
            compare_field("host_len",   9'(want.host_len),   9'(got.host_len));
            compare_field("port_start", 9'(want.port_start), 9'(got.port_start));
            compare_field("port_len",   9'(want.port_len),   9'(got.port_len));
            compare_field("too_long",   9'(want.too_long),   9'(got.too_long));
            words_checked++;
            if (want.too_long)
                overlong_words++;
            if (want.port_len != 0)
                port_words++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    uas_in_if  in_if();
    uas_out_if out_if();

    uri_authority_splitter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    authority_scoreboard sb = new();

    // Idle rates in percent; the main sequence changes them per phase.
    int src_idle_pct = 8;
    int snk_idle_pct = 65;

    int bytes_sent = 0;
    int authorities_sent = 0;

    // Authority under construction, sent as a whole by send_text.
    logic [7:0] text[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready is redrawn at every falling edge.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor: both channels are sampled at the rising edge. Inputs are noted
    // before outputs are checked, although a result passes the input and output
    // registers, so it can never belong to a byte accepted on the same edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_byte(in_if.byte_in, in_if.last_byte);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.user_len   = out_if.user_len;
            got.pass_start = out_if.pass_start;
            got.pass_len   = out_if.pass_len;
            got.host_start = out_if.host_start;
            got.host_len   = out_if.host_len;
            got.port_start = out_if.port_start;
            got.port_len   = out_if.port_len;
            got.too_long   = out_if.too_long;
            sb.check_word(got);
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
                break;
        end
        $error("no word accepted for %0d cycles", STALL_LIMIT);
        $display("uri_authority_splitter test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Text building helpers. They all append to the authority under
    // construction.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_char(t_char_class cls);
        string names;
        logic [7:0] b;
        names = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_~[]%";
        case (cls)
            CLS_NAME: begin
                b = names[$urandom_range(0, names.len() - 1)];
            end
            CLS_DIGIT: begin
                b = 8'(CHAR_ZERO + $urandom_range(0, 9));
            end
            default: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_AT || b == CHAR_COLON);
            end
        endcase
        return b;
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    function automatic void put_rep(logic [7:0] b, int n);
        repeat (n) text.push_back(b);
    endfunction

    // A field of n content bytes; mostly name characters, sometimes any
    // non-separator byte so that every bit pattern shows up.
    function automatic void put_field(int n);
        repeat (n)
            text.push_back(pick_char(($urandom_range(0, 99) < 80) ? CLS_NAME : CLS_PLAIN));
    endfunction

    // Field lengths are short, with an occasional long one to reach clipping.
    function automatic int field_len();
        return ($urandom_range(0, 99) < 3) ? $urandom_range(60, 140) : $urandom_range(0, 8);
    endfunction

    // [user[:pass]@]host[:port]
    function automatic void build_well_formed();
        int n;
        if ($urandom_range(0, 99) < 65) begin
            put_field(field_len());
            if ($urandom_range(0, 99) < 55) begin
                text.push_back(CHAR_COLON);
                put_field(field_len());
            end
            text.push_back(CHAR_AT);
        end
        put_field(field_len());
        if ($urandom_range(0, 99) < 70) begin
            text.push_back(CHAR_COLON);
            n = $urandom_range(0, 10);
            repeat (n) text.push_back(pick_char(CLS_DIGIT));
            // Sometimes a stray character spoils the port.
            if (n > 0 && $urandom_range(0, 99) < 20)
                text[text.size() - 1 - $urandom_range(0, n - 1)] = pick_char(CLS_PLAIN);
        end
        if (text.size() == 0)
            text.push_back(pick_char(CLS_NAME));
    endfunction

    // A well-formed authority with a few bytes overwritten by separators or
    // arbitrary values.
    function automatic void build_broken();
        int k, pos, roll;
        build_well_formed();
        k = $urandom_range(1, 3);
        repeat (k) begin
            pos = $urandom_range(0, text.size() - 1);
            roll = $urandom_range(0, 2);
            if (roll == 0)
                text[pos] = CHAR_AT;
            else if (roll == 1)
                text[pos] = CHAR_COLON;
            else
                text[pos] = 8'($urandom_range(0, 255));
        end
    endfunction

    // Short random text with the separators and digits favored.
    function automatic void build_noise();
        int n, roll;
        n = $urandom_range(1, 12);
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                text.push_back(CHAR_AT);
            else if (roll < 40)
                text.push_back(CHAR_COLON);
            else if (roll < 55)
                text.push_back(pick_char(CLS_DIGIT));
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Both are entered right after a falling edge and leave right
    // after one, so valid stays high across back-to-back words.
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.byte_in   <= b;
        in_if.last_byte <= is_last;
        do @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic send_text();
        int n;
        n = text.size();
        for (int i = 0; i < n; i++)
            send_byte(text[i], i == n - 1);
        bytes_sent += n;
        authorities_sent++;
        text.delete();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        string plain_cases[$];
        int phase_start, phase_auths, roll;

        in_if.valid     <= 1'b0;
        in_if.byte_in   <= '0;
        in_if.last_byte <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases, under the first idling pattern.
        plain_cases = '{
            "h",                // single byte
            "@",                // '@' at position 0: no credentials
            "@h:80",
            "user@host:8080",
            "u:pw@host:443",
            ":80",              // colon first: everything is host
            "host:",            // empty port
            "host:8x0",         // spoiled port
            "host:1234567890",  // port clipped
            "host:12345678x9",  // stray byte past the checked window
            "u@:80",            // colon right after the '@'
            ":pw@h",            // colon at position 0 before the '@'
            "u:p:q@h:1",
            "a@b@c:2",          // only the first '@' counts
            "a:b:c",
            "u:@h",             // empty password
            "u:x@h:12"          // bad byte after the first colon only
        };
        foreach (plain_cases[i]) begin
            put_str(plain_cases[i]);
            send_text();
        end

        // Zero and all-ones bytes as ordinary characters.
        put_rep(8'h00, 1);
        put_rep(8'hff, 1);
        put_str("x:9");
        text.push_back(8'h00);
        send_text();

        // Long user and password, each past its clip, with the '@' on the
        // final accepted position so that the host offset wraps. The bytes
        // past the limit, separators included, must be ignored.
        put_rep("u", USER_MAX + 1);
        text.push_back(CHAR_COLON);
        put_rep("p", AUTH_MAX - USER_MAX - 3);
        text.push_back(CHAR_AT);
        put_str("h:1");
        send_text();

        // Long host past its clip, followed by a port.
        put_rep("h", HOST_MAX + 1);
        put_str(":22");
        send_text();

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 8;
                    snk_idle_pct = 65;
                end
                1: begin
                    src_idle_pct = 65;
                    snk_idle_pct = 8;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            phase_auths = 0;
            while (bytes_sent - phase_start < PHASE_BYTES || phase_auths < PHASE_AUTHS) begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    build_well_formed();
                else if (roll < 88)
                    build_broken();
                else
                    build_noise();
                send_text();
                phase_auths++;
            end
        end
        in_if.valid <= 1'b0;

        // Wait for the last results; the watchdog catches a hang here.
        while (sb.expected_splits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d authorities in %0d bytes under three idling patterns.",
                 authorities_sent, bytes_sent);
        $display("Checked %0d result words: %0d with a port, %0d overlong, %0d errors.",
                 sb.words_checked, sb.port_words, sb.overlong_words, sb.errors);
        if (sb.errors == 0)
            $display("uri_authority_splitter test passed");
        else
            $display("uri_authority_splitter test failed");
        $finish;
    end

endmodule
